// ----- hdl/dhbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Detection head box decode package
// Shared beat types, register indexes and constants for the box decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dhbd_pkg;

   // Number of box features (cx, cy, w, h) that open every anchor.
   localparam int BoxFieldCount = 4;
   // Boxes of this size or less in either direction are dropped.
   localparam int MinBoxSize = 5;
   // Entries in the queue between the front and back parts.
   localparam int QueueDepth = 4;

   // Configuration register indexes.
   localparam logic [2:0] CsrScoreThreshold = 3'd0;
   localparam logic [2:0] CsrInverseScale   = 3'd1;
   localparam logic [2:0] CsrPadWidth       = 3'd2;
   localparam logic [2:0] CsrPadHeight      = 3'd3;
   localparam logic [2:0] CsrImageWidth     = 3'd4;
   localparam logic [2:0] CsrImageHeight    = 3'd5;

   // Input beat: one anchor feature.
   typedef struct packed {
      logic signed [23:0] feature_value;
      logic               anchor_end;
   } req_payload_type;

   // Result beat: one decoded box.
   typedef struct packed {
      logic [11:0] left_x;
      logic [11:0] top_y;
      logic [11:0] box_width;
      logic [11:0] box_height;
      logic [6:0]  class_index;
      logic [22:0] best_score;
   } rsp_payload_type;

   // Anchor that passed the score test, handed from front to back.
   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [23:0] w;
      logic signed [23:0] h;
      logic [22:0]        best;
      logic [6:0]         cls;
   } job_type;

   // Letterbox and clipping settings used by the back part.
   typedef struct packed {
      logic [22:0] inverse_scale;
      logic [11:0] pad_width;
      logic [11:0] pad_height;
      logic [11:0] image_width;
      logic [11:0] image_height;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hdl/dhbd_front.sv -----
// ----------------------------------------------------------------------------
// Detection head box decode front part
// Accepts feature beats, stores the box fields, keeps the running argmax and
// pushes anchors whose best score beats the threshold into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dhbd_front #(
   parameter int MAX_CLASSES = 80
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire dhbd_pkg::req_payload_type req_payload,
   input  wire logic                     queue_full,
   input  wire logic [8:0]               score_threshold,
   output logic                          push,
   output dhbd_pkg::job_type             job
);

   localparam logic [7:0] MaxClassesC = 8'(MAX_CLASSES);
   localparam logic [7:0] BoxCountC   = 8'(dhbd_pkg::BoxFieldCount);

   logic               accept;
   logic [7:0]         cnt_ff, cnt_in;
   logic signed [23:0] box_ff [dhbd_pkg::BoxFieldCount];
   logic signed [23:0] box_in [dhbd_pkg::BoxFieldCount];
   logic signed [23:0] best_ff, best_in;
   logic [6:0]         cls_ff, cls_in;
   logic [7:0]         score_idx;
   logic               is_box;
   logic               take;
   logic signed [23:0] upd_best;
   logic [6:0]         upd_cls;
   logic               pass;

   // A beat is taken whenever the queue has room.
   assign accept = req_valid && !queue_full;

   // Classify the beat and fold it into the running argmax; first maximum wins.
   assign is_box    = cnt_ff < BoxCountC;
   assign score_idx = cnt_ff - BoxCountC;
   assign take      = !is_box && (score_idx < MaxClassesC) &&
                      ((score_idx == 8'd0) || (req_payload.feature_value > best_ff));
   assign upd_best  = take ? req_payload.feature_value : best_ff;
   assign upd_cls   = take ? score_idx[6:0] : cls_ff;
   assign pass      = !is_box && (upd_best > $signed({15'd0, score_threshold}));

   // Next state of the anchor tracking.
   always_comb begin
      cnt_in  = cnt_ff;
      best_in = best_ff;
      cls_in  = cls_ff;
      box_in  = box_ff;
      if (accept) begin
         if (is_box) begin
            box_in[cnt_ff[1:0]] = req_payload.feature_value;
         end
         if (req_payload.anchor_end) begin
            cnt_in  = 8'd0;
            best_in = 24'sd0;
            cls_in  = 7'd0;
         end else begin
            cnt_in  = (cnt_ff == 8'hFF) ? cnt_ff : cnt_ff + 8'd1;
            best_in = upd_best;
            cls_in  = upd_cls;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 8'd0;
         best_ff <= 24'sd0;
         cls_ff  <= 7'd0;
      end else begin
         cnt_ff  <= cnt_in;
         best_ff <= best_in;
         cls_ff  <= cls_in;
      end
   end

   // Box fields are always rewritten before an anchor can produce a result.
   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   // Hand a passing anchor to the back part.
   assign push     = accept && req_payload.anchor_end && pass;
   assign job.cx   = box_ff[0];
   assign job.cy   = box_ff[1];
   assign job.w    = box_ff[2];
   assign job.h    = box_ff[3];
   assign job.best = upd_best[22:0];
   assign job.cls  = upd_cls;

   // The anchor state clears after every closing beat.
   a_clear_on_end : assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.anchor_end) |=> (cnt_ff == 8'd0 && best_ff == 24'sd0))
      else $error("anchor state not cleared after closing beat");

   // Within an anchor the counter steps by one until it saturates.
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (accept && !req_payload.anchor_end && cnt_ff != 8'hFF) |=>
      (cnt_ff == $past(cnt_ff) + 8'd1))
      else $error("feature counter did not advance");

endmodule

`default_nettype wire

// ----- hdl/dhbd_queue.sv -----
// ----------------------------------------------------------------------------
// Detection head box decode queue
// Short first-in first-out buffer of decoded anchors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dhbd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dhbd_pkg::job_type push_data,
   output logic                   full,
   output logic                   pop_valid,
   input  wire logic              pop,
   output dhbd_pkg::job_type      pop_data
);

   localparam int PtrW = $clog2(dhbd_pkg::QueueDepth);
   localparam int CntW = $clog2(dhbd_pkg::QueueDepth + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(dhbd_pkg::QueueDepth);

   dhbd_pkg::job_type mem_ff [dhbd_pkg::QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == DepthC);
   assign pop_valid = (count_ff != '0);
   assign do_pop    = pop && pop_valid;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front must never push into a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

`default_nettype wire

// ----- hdl/dhbd_back.sv -----
// ----------------------------------------------------------------------------
// Detection head box decode back part
// Undoes the letterbox, clips the box to the image, drops small boxes and
// holds the result beat in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dhbd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dhbd_pkg::cfg_type cfg,
   input  wire logic              job_valid,
   input  wire dhbd_pkg::job_type job,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dhbd_pkg::rsp_payload_type rsp_payload
);

   localparam logic signed [27:0] MinSizeC = 28'(dhbd_pkg::MinBoxSize);

   // Stage valids and ready chain.
   logic a_v_ff, a_v_in, b_v_ff, b_v_in, c_v_ff, c_v_in, o_v_ff, o_v_in;
   logic a_rdy, b_rdy, c_rdy, o_rdy;

   // Stage A: centers with the half padding removed.
   logic signed [24:0] a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;
   logic signed [23:0] a_w_ff, a_h_ff;
   logic [22:0]        a_best_ff, b_best_ff, c_best_ff;
   logic [6:0]         a_cls_ff, b_cls_ff, c_cls_ff;

   // Stage B: products.
   logic signed [48:0] b_cx_ff, b_cx_in, b_cy_ff, b_cy_in;
   logic signed [47:0] b_sx_ff, b_sx_in, b_sy_ff, b_sy_in;

   // Stage C: corner and unclipped size.
   logic signed [50:0] tl_x, tl_y;
   logic [25:0]        c_lx_ff, c_lx_in, c_ly_ff, c_ly_in;
   logic signed [23:0] c_ex_ff, c_ex_in, c_ey_ff, c_ey_in;

   // Clip and size test in front of the output register.
   logic signed [27:0] room_x, room_y, clip_x, clip_y;
   logic               keep;
   dhbd_pkg::rsp_payload_type o_data_ff, o_data_in;

   assign o_rdy   = !o_v_ff || !rsp_stall;
   assign c_rdy   = !c_v_ff || o_rdy;
   assign b_rdy   = !b_v_ff || c_rdy;
   assign a_rdy   = !a_v_ff || b_rdy;
   assign job_pop = job_valid && a_rdy;

   // Remove the half padding, scaled to Q.8.
   assign a_dx_in = 25'(job.cx) - $signed({6'd0, cfg.pad_width[11:1], 8'd0});
   assign a_dy_in = 25'(job.cy) - $signed({6'd0, cfg.pad_height[11:1], 8'd0});

   // Multiply by the reciprocal scale.
   assign b_cx_in = 49'(a_dx_ff) * 49'($signed({1'b0, cfg.inverse_scale}));
   assign b_cy_in = 49'(a_dy_ff) * 49'($signed({1'b0, cfg.inverse_scale}));
   assign b_sx_in = 48'(a_w_ff) * 48'($signed({1'b0, cfg.inverse_scale}));
   assign b_sy_in = 48'(a_h_ff) * 48'($signed({1'b0, cfg.inverse_scale}));

   // Twice the left edge, truncated and clamped at zero; size truncated.
   assign tl_x    = (51'(b_cx_ff) <<< 1) - 51'(b_sx_ff);
   assign tl_y    = (51'(b_cy_ff) <<< 1) - 51'(b_sy_ff);
   assign c_lx_in = (!tl_x[50] && (tl_x != '0)) ? tl_x[50:25] : 26'd0;
   assign c_ly_in = (!tl_y[50] && (tl_y != '0)) ? tl_y[50:25] : 26'd0;
   assign c_ex_in = b_sx_ff[47] ? -24'sd1 : $signed({1'b0, b_sx_ff[46:24]});
   assign c_ey_in = b_sy_ff[47] ? -24'sd1 : $signed({1'b0, b_sy_ff[46:24]});

   // Limit the size to the room left in the image and drop small boxes.
   assign room_x = $signed({16'd0, cfg.image_width}) - $signed({2'd0, c_lx_ff});
   assign room_y = $signed({16'd0, cfg.image_height}) - $signed({2'd0, c_ly_ff});
   assign clip_x = (28'(c_ex_ff) > room_x) ? room_x : 28'(c_ex_ff);
   assign clip_y = (28'(c_ey_ff) > room_y) ? room_y : 28'(c_ey_ff);
   assign keep   = (clip_x > MinSizeC) && (clip_y > MinSizeC);

   always_comb begin
      o_data_in.left_x      = c_lx_ff[11:0];
      o_data_in.top_y       = c_ly_ff[11:0];
      o_data_in.box_width   = clip_x[11:0];
      o_data_in.box_height  = clip_y[11:0];
      o_data_in.class_index = c_cls_ff;
      o_data_in.best_score  = c_best_ff;
   end

   // Stage valid update; a dropped box simply leaves stage C.
   always_comb begin
      a_v_in = a_rdy ? job_valid : a_v_ff;
      b_v_in = b_rdy ? a_v_ff : b_v_ff;
      c_v_in = c_rdy ? b_v_ff : c_v_ff;
      o_v_in = o_rdy ? (c_v_ff && keep) : o_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         c_v_ff <= c_v_in;
         o_v_ff <= o_v_in;
      end
   end

   // Stage payload registers.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_w_ff    <= job.w;
         a_h_ff    <= job.h;
         a_best_ff <= job.best;
         a_cls_ff  <= job.cls;
      end
      if (b_rdy && a_v_ff) begin
         b_cx_ff   <= b_cx_in;
         b_cy_ff   <= b_cy_in;
         b_sx_ff   <= b_sx_in;
         b_sy_ff   <= b_sy_in;
         b_best_ff <= a_best_ff;
         b_cls_ff  <= a_cls_ff;
      end
      if (c_rdy && b_v_ff) begin
         c_lx_ff   <= c_lx_in;
         c_ly_ff   <= c_ly_in;
         c_ex_ff   <= c_ex_in;
         c_ey_ff   <= c_ey_in;
         c_best_ff <= b_best_ff;
         c_cls_ff  <= b_cls_ff;
      end
      if (o_rdy && c_v_ff && keep) begin
         o_data_ff <= o_data_in;
      end
   end

   assign rsp_valid   = o_v_ff;
   assign rsp_payload = o_data_ff;

   // Every emitted box is larger than the minimum size in both directions.
   a_size_kept : assert property (@(posedge clock) disable iff (reset)
      o_v_ff |-> (o_data_ff.box_width > 12'(dhbd_pkg::MinBoxSize) &&
                  o_data_ff.box_height > 12'(dhbd_pkg::MinBoxSize)))
      else $error("emitted box at or below minimum size");

   // A blocked first stage keeps its contents.
   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      (a_v_ff && !b_rdy) |=> (a_v_ff && $stable(a_dx_ff) && $stable(a_dy_ff)))
      else $error("stage A lost data while blocked");

endmodule

`default_nettype wire

// ----- hdl/detection_head_box_decode_core.sv -----
// ----------------------------------------------------------------------------
// Detection head box decode core
// Decodes detector-head anchors streamed one feature per beat into boxes in
// original image pixels, with class index and best score.
// ----------------------------------------------------------------------------
// Throughput: one feature beat per cycle while the queue is not full; the
// argmax is a single compare. After the anchor's closing beat is accepted,
// its result passes the queue, offset, multiply, corner and output registers.
// The four-entry queue stalls the input only when the result side backs up.
// Reset is synchronous and active high; it clears the anchor state, the
// queue and pipeline valids and loads the register reset values.
`default_nettype none

module detection_head_box_decode_core #(
   parameter int MAX_CLASSES = 80
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire dhbd_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output dhbd_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_wr_en,
   input  wire logic [2:0]                csr_index,
   input  wire logic [22:0]               csr_wr_data
);

   logic [8:0]        thr_ff, thr_in;
   dhbd_pkg::cfg_type cfg_ff, cfg_in;
   logic              push, queue_full, job_valid, job_pop;
   dhbd_pkg::job_type push_job, pop_job;

   // Configuration register writes.
   always_comb begin
      thr_in = thr_ff;
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dhbd_pkg::CsrScoreThreshold: thr_in = csr_wr_data[8:0];
            dhbd_pkg::CsrInverseScale:   cfg_in.inverse_scale = csr_wr_data;
            dhbd_pkg::CsrPadWidth:       cfg_in.pad_width = csr_wr_data[11:0];
            dhbd_pkg::CsrPadHeight:      cfg_in.pad_height = csr_wr_data[11:0];
            dhbd_pkg::CsrImageWidth:     cfg_in.image_width = csr_wr_data[11:0];
            dhbd_pkg::CsrImageHeight:    cfg_in.image_height = csr_wr_data[11:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff              <= 9'd64;
         cfg_ff.inverse_scale <= 23'd65536;
         cfg_ff.pad_width    <= 12'd0;
         cfg_ff.pad_height   <= 12'd0;
         cfg_ff.image_width  <= 12'd640;
         cfg_ff.image_height <= 12'd480;
      end else begin
         thr_ff <= thr_in;
         cfg_ff <= cfg_in;
      end
   end

   // The input side stalls only while the queue is full.
   assign req_stall = queue_full;

   dhbd_front #(
      .MAX_CLASSES(MAX_CLASSES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_payload    (req_payload),
      .queue_full     (queue_full),
      .score_threshold(thr_ff),
      .push           (push),
      .job            (push_job)
   );

   dhbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_job),
      .full     (queue_full),
      .pop_valid(job_valid),
      .pop      (job_pop),
      .pop_data (pop_job)
   );

   dhbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job        (pop_job),
      .job_pop    (job_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire
